// ===== rtl/bcdclk_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcdclk_pkg
// Shared types and constants of the BCD time-of-day alarm clock: action codes,
// controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bcdclk_pkg;

   localparam int DEFAULT_ALARM_SLOTS = 8;

   localparam int HOUR_MAX   = 23;
   localparam int MINSEC_MAX = 59;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_SET  = 2'd1,
      ACT_ADD  = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_req;
      logic mem_read;
      logic compare;
      logic update;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/bcdclk_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcdclk_ctrl
// Controller: accepts a transaction, steps the alarm scan one entry per
// read/compare pair, then issues the update and the one-cycle response.
// ----------------------------------------------------------------------------
module bcdclk_ctrl
   import bcdclk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  status_type      status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.scan_needed ? ST_READ : ST_UPDATE;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = status.scan_last ? ST_UPDATE : ST_READ;
         end
         ST_UPDATE: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   a_respond_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after the response");

   a_update_before_respond: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> $past(cmd.update))
      else $error("response issued without a preceding update");

endmodule

`default_nettype wire

// ===== rtl/bcdclk_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcdclk_dp
// Datapath: request holding registers, BCD time digits, alarm store memory
// with a registered read port, the hour/minute compare and the result flags.
// ----------------------------------------------------------------------------
module bcdclk_dp
   import bcdclk_pkg::*;
#(
   parameter int ALARM_SLOTS = DEFAULT_ALARM_SLOTS
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [1:0] req_action,
   input  wire logic [4:0] req_hours_in,
   input  wire logic [5:0] req_minutes_in,
   input  wire logic [5:0] req_seconds_in,
   input  cmd_type         cmd,
   output status_type      status,
   output logic [1:0]      hour_tens,
   output logic [3:0]      hour_units,
   output logic [2:0]      minute_tens,
   output logic [3:0]      minute_units,
   output logic [2:0]      second_tens,
   output logic [3:0]      second_units,
   output logic            alarm_match,
   output logic            alarm_dropped
);

   localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

   function automatic logic [6:0] bin_to_bcd(input logic [5:0] v);
      logic [2:0] tens;
      logic [5:0] units;
      if (v >= 6'd50) begin
         tens = 3'd5;
      end else if (v >= 6'd40) begin
         tens = 3'd4;
      end else if (v >= 6'd30) begin
         tens = 3'd3;
      end else if (v >= 6'd20) begin
         tens = 3'd2;
      end else if (v >= 6'd10) begin
         tens = 3'd1;
      end else begin
         tens = 3'd0;
      end
      units = v - 6'({3'd0, tens} * 6'd10);
      return {tens, units[3:0]};
   endfunction

   action_type       action_ff;
   logic [4:0]       hours_ff;
   logic [5:0]       minutes_ff;
   logic [5:0]       seconds_ff;

   logic [1:0]       hr_tens_ff;
   logic [3:0]       hr_units_ff;
   logic [2:0]       min_tens_ff;
   logic [3:0]       min_units_ff;
   logic [2:0]       sec_tens_ff;
   logic [3:0]       sec_units_ff;
   logic [1:0]       hr_tens_in;
   logic [3:0]       hr_units_in;
   logic [2:0]       min_tens_in;
   logic [3:0]       min_units_in;
   logic [2:0]       sec_tens_in;
   logic [3:0]       sec_units_in;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_idx_ff;
   logic [CNT_W-1:0] scan_next;
   logic             ring_ff;
   logic             dropped_ff;

   logic [10:0]      alarm_mem [ALARM_SLOTS];
   logic [10:0]      rd_data_ff;

   logic [4:0]       cur_hour;
   logic [5:0]       cur_minute;
   logic             match;
   logic             store_full;
   logic             add_write;
   logic [6:0]       set_hour_bcd;
   logic [6:0]       set_min_bcd;
   logic [6:0]       set_sec_bcd;

   assign cur_hour   = 5'({3'd0, hr_tens_ff} * 5'd10) + {1'b0, hr_units_ff};
   assign cur_minute = 6'({3'd0, min_tens_ff} * 6'd10) + {2'b00, min_units_ff};
   assign match      = (rd_data_ff[10:6] == cur_hour) && (rd_data_ff[5:0] == cur_minute);
   assign store_full = (count_ff >= CNT_W'(ALARM_SLOTS));
   assign add_write  = cmd.update && (action_ff == ACT_ADD) && !store_full;
   assign scan_next  = scan_idx_ff + CNT_W'(1);

   assign status.scan_needed = (action_type'(req_action) == ACT_TICK) && (count_ff != '0);
   assign status.scan_last   = (scan_next == count_ff);

   assign set_hour_bcd = bin_to_bcd({1'b0, hours_ff});
   assign set_min_bcd  = bin_to_bcd(minutes_ff);
   assign set_sec_bcd  = bin_to_bcd(seconds_ff);

   // hold request fields
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff  <= action_type'(req_action);
         hours_ff   <= req_hours_in;
         minutes_ff <= req_minutes_in;
         seconds_ff <= req_seconds_in;
      end
   end

   // alarm store
   always_ff @(posedge clock) begin
      if (add_write) begin
         alarm_mem[count_ff[IDX_W-1:0]] <= {hours_ff, minutes_ff};
      end
      if (cmd.mem_read) begin
         rd_data_ff <= alarm_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // next time value
   always_comb begin
      hr_tens_in   = hr_tens_ff;
      hr_units_in  = hr_units_ff;
      min_tens_in  = min_tens_ff;
      min_units_in = min_units_ff;
      sec_tens_in  = sec_tens_ff;
      sec_units_in = sec_units_ff;
      if (cmd.update) begin
         case (action_ff)
            ACT_TICK: begin
               if (sec_units_ff < 4'd9) begin
                  sec_units_in = sec_units_ff + 4'd1;
               end else begin
                  sec_units_in = 4'd0;
                  if (sec_tens_ff < 3'd5) begin
                     sec_tens_in = sec_tens_ff + 3'd1;
                  end else begin
                     sec_tens_in = 3'd0;
                     if (min_units_ff < 4'd9) begin
                        min_units_in = min_units_ff + 4'd1;
                     end else begin
                        min_units_in = 4'd0;
                        if (min_tens_ff < 3'd5) begin
                           min_tens_in = min_tens_ff + 3'd1;
                        end else begin
                           min_tens_in = 3'd0;
                           if (cur_hour >= 5'(HOUR_MAX)) begin
                              hr_tens_in  = 2'd0;
                              hr_units_in = 4'd0;
                           end else if (hr_units_ff >= 4'd9) begin
                              hr_units_in = 4'd0;
                              hr_tens_in  = hr_tens_ff + 2'd1;
                           end else begin
                              hr_units_in = hr_units_ff + 4'd1;
                           end
                        end
                     end
                  end
               end
            end
            ACT_SET: begin
               if (hours_ff <= 5'(HOUR_MAX)) begin
                  hr_tens_in  = set_hour_bcd[5:4];
                  hr_units_in = set_hour_bcd[3:0];
               end
               if (minutes_ff <= 6'(MINSEC_MAX)) begin
                  min_tens_in  = set_min_bcd[6:4];
                  min_units_in = set_min_bcd[3:0];
               end
               if (seconds_ff <= 6'(MINSEC_MAX)) begin
                  sec_tens_in  = set_sec_bcd[6:4];
                  sec_units_in = set_sec_bcd[3:0];
               end
            end
            default: begin
               hr_tens_in = hr_tens_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hr_tens_ff   <= 2'd1;
         hr_units_ff  <= 4'd2;
         min_tens_ff  <= 3'd0;
         min_units_ff <= 4'd0;
         sec_tens_ff  <= 3'd0;
         sec_units_ff <= 4'd0;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         ring_ff      <= 1'b0;
         dropped_ff   <= 1'b0;
      end else begin
         hr_tens_ff   <= hr_tens_in;
         hr_units_ff  <= hr_units_in;
         min_tens_ff  <= min_tens_in;
         min_units_ff <= min_units_in;
         sec_tens_ff  <= sec_tens_in;
         sec_units_ff <= sec_units_in;
         if (cmd.load_req) begin
            scan_idx_ff <= '0;
            ring_ff     <= 1'b0;
            dropped_ff  <= 1'b0;
         end
         if (cmd.compare) begin
            scan_idx_ff <= scan_next;
            if (match) begin
               ring_ff <= 1'b1;
            end
         end
         if (add_write) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.update && (action_ff == ACT_ADD) && store_full) begin
            dropped_ff <= 1'b1;
         end
      end
   end

   assign hour_tens     = hr_tens_ff;
   assign hour_units    = hr_units_ff;
   assign minute_tens   = min_tens_ff;
   assign minute_units  = min_units_ff;
   assign second_tens   = sec_tens_ff;
   assign second_units  = sec_units_ff;
   assign alarm_match   = ring_ff;
   assign alarm_dropped = dropped_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ALARM_SLOTS))
      else $error("alarm count beyond store size");

   a_ring_only_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && ring_ff |-> (action_ff == ACT_TICK))
      else $error("ring raised on a non-tick transaction");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && dropped_ff |-> store_full && (action_ff == ACT_ADD))
      else $error("alarm dropped while store had room");

endmodule

`default_nettype wire

// ===== rtl/bcd_time_of_day_alarm_clock.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_time_of_day_alarm_clock
// 24-hour BCD clock with an append-only store of alarm times.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; start is ignored
// while busy. Each transaction gives one result, shown for exactly one cycle
// with rsp_strobe high, and the receiver cannot stall it. Set-time, add-alarm
// and the unused action pass from acceptance through the update state to the
// result, then the block is idle again. A tick scans the stored alarms
// through the single read port of the alarm memory, with a read state and a
// compare state per entry, before the update and the result; with an empty
// store it goes straight to the update. The time resets to 12:00:00 with an
// empty store.
// ----------------------------------------------------------------------------
module bcd_time_of_day_alarm_clock
   import bcdclk_pkg::*;
#(
   parameter int ALARM_SLOTS = DEFAULT_ALARM_SLOTS
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_action,
   input  wire logic [4:0] req_hours_in,
   input  wire logic [5:0] req_minutes_in,
   input  wire logic [5:0] req_seconds_in,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_hour_tens,
   output logic [3:0]      rsp_hour_units,
   output logic [2:0]      rsp_minute_tens,
   output logic [3:0]      rsp_minute_units,
   output logic [2:0]      rsp_second_tens,
   output logic [3:0]      rsp_second_units,
   output logic            rsp_alarm_match,
   output logic            rsp_alarm_dropped
);

   cmd_type    cmd;
   status_type status;

   bcdclk_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bcdclk_dp #(
      .ALARM_SLOTS (ALARM_SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_hours_in   (req_hours_in),
      .req_minutes_in (req_minutes_in),
      .req_seconds_in (req_seconds_in),
      .cmd            (cmd),
      .status         (status),
      .hour_tens      (rsp_hour_tens),
      .hour_units     (rsp_hour_units),
      .minute_tens    (rsp_minute_tens),
      .minute_units   (rsp_minute_units),
      .second_tens    (rsp_second_tens),
      .second_units   (rsp_second_units),
      .alarm_match    (rsp_alarm_match),
      .alarm_dropped  (rsp_alarm_dropped)
   );

   assign rsp_strobe = cmd.respond;

endmodule

`default_nettype wire

// ===== verif/bcd_time_of_day_alarm_clock_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BCD time-of-day alarm clock checker
// Watches the command and result channels of the clock. It keeps its own copy
// of the time digits and the alarm store, works out the reading each accepted
// transaction must produce, and compares every strobed result field by field
// with the oldest reading still owed. It reports the failure count and the
// number of readings still outstanding.
// ----------------------------------------------------------------------------
module bcd_time_of_day_alarm_clock_checker
   import bcdclk_pkg::*;
#(
   parameter int ALARM_SLOTS = DEFAULT_ALARM_SLOTS
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  wire logic [1:0] req_action,
   input  wire logic [4:0] req_hours_in,
   input  wire logic [5:0] req_minutes_in,
   input  wire logic [5:0] req_seconds_in,
   input  wire logic       rsp_strobe,
   input  wire logic [1:0] rsp_hour_tens,
   input  wire logic [3:0] rsp_hour_units,
   input  wire logic [2:0] rsp_minute_tens,
   input  wire logic [3:0] rsp_minute_units,
   input  wire logic [2:0] rsp_second_tens,
   input  wire logic [3:0] rsp_second_units,
   input  wire logic       rsp_alarm_match,
   input  wire logic       rsp_alarm_dropped,
   output int              failure_count,
   output int              readings_owed
);

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] minute_tens;
      logic [3:0] minute_units;
      logic [2:0] second_tens;
      logic [3:0] second_units;
      logic       alarm_match;
      logic       alarm_dropped;
   } clock_reading_t;

   logic [1:0]     hr_tens;
   logic [3:0]     hr_units;
   logic [2:0]     min_tens;
   logic [3:0]     min_units;
   logic [2:0]     sec_tens;
   logic [3:0]     sec_units;
   logic [10:0]    alarm_times [ALARM_SLOTS];
   int             alarm_total;
   clock_reading_t owed_readings [$];
   int             reading_index;

   initial begin
      failure_count = 0;
      readings_owed = 0;
      reading_index = 0;
   end

   function automatic string reading_text(input clock_reading_t r);
      return $sformatf("%0d%0d:%0d%0d:%0d%0d ring %0b dropped %0b", r.hour_tens,
                       r.hour_units, r.minute_tens, r.minute_units, r.second_tens,
                       r.second_units, r.alarm_match, r.alarm_dropped);
   endfunction

   task automatic predict_reading(input action_type act, input logic [4:0] hrs,
                                  input logic [5:0] mins, input logic [5:0] secs,
                                  output clock_reading_t reading);
      int   hour_now;
      int   minute_now;
      int   i;
      logic ring;
      logic dropped;
      ring       = 1'b0;
      dropped    = 1'b0;
      hour_now   = hr_tens * 10 + hr_units;
      minute_now = min_tens * 10 + min_units;
      case (act)
         ACT_TICK: begin
            for (i = 0; i < alarm_total; i++) begin
               if (int'(alarm_times[i][10:6]) == hour_now &&
                   int'(alarm_times[i][5:0]) == minute_now) begin
                  ring = 1'b1;
               end
            end
            // advance one second with BCD carries
            if (sec_units < 9) begin
               sec_units++;
            end else begin
               sec_units = '0;
               if (sec_tens < 5) begin
                  sec_tens++;
               end else begin
                  sec_tens = '0;
                  if (min_units < 9) begin
                     min_units++;
                  end else begin
                     min_units = '0;
                     if (min_tens < 5) begin
                        min_tens++;
                     end else begin
                        min_tens = '0;
                        if (hour_now >= HOUR_MAX) begin
                           hr_tens  = '0;
                           hr_units = '0;
                        end else if (hr_units >= 9) begin
                           hr_units = '0;
                           hr_tens++;
                        end else begin
                           hr_units++;
                        end
                     end
                  end
               end
            end
         end
         ACT_SET: begin
            if (hrs <= HOUR_MAX) begin
               hr_tens  = 2'(hrs / 10);
               hr_units = 4'(hrs % 10);
            end
            if (mins <= MINSEC_MAX) begin
               min_tens  = 3'(mins / 10);
               min_units = 4'(mins % 10);
            end
            if (secs <= MINSEC_MAX) begin
               sec_tens  = 3'(secs / 10);
               sec_units = 4'(secs % 10);
            end
         end
         ACT_ADD: begin
            if (alarm_total < ALARM_SLOTS) begin
               alarm_times[alarm_total] = {hrs, mins};
               alarm_total++;
            end else begin
               dropped = 1'b1;
            end
         end
         default: begin
         end
      endcase
      reading = '{hr_tens, hr_units, min_tens, min_units, sec_tens, sec_units,
                  ring, dropped};
   endtask

   always @(posedge clock) begin : watch_channels
      clock_reading_t seen;
      clock_reading_t wanted;
      if (reset) begin
         hr_tens     = 2'd1;
         hr_units    = 4'd2;
         min_tens    = '0;
         min_units   = '0;
         sec_tens    = '0;
         sec_units   = '0;
         alarm_total = 0;
         foreach (alarm_times[i]) alarm_times[i] = '0;
         owed_readings.delete();
      end else begin
         if (rsp_strobe) begin
            seen = '{rsp_hour_tens, rsp_hour_units, rsp_minute_tens, rsp_minute_units,
                     rsp_second_tens, rsp_second_units, rsp_alarm_match,
                     rsp_alarm_dropped};
            if (owed_readings.size() == 0) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("[%0t] result %0d arrived with no transaction pending",
                           $realtime, reading_index);
               end
            end else begin
               wanted = owed_readings.pop_front();
               if (seen !== wanted) begin
                  failure_count++;
                  if (failure_count <= 10) begin
                     $display("[%0t] result %0d mismatch: expected %s, got %s",
                              $realtime, reading_index, reading_text(wanted),
                              reading_text(seen));
                  end
               end
            end
            reading_index++;
         end
         if (start && !busy) begin
            predict_reading(action_type'(req_action), req_hours_in, req_minutes_in,
                            req_seconds_in, wanted);
            owed_readings.push_back(wanted);
         end
      end
      readings_owed <= owed_readings.size();
   end

endmodule

// ===== verif/tb_bcd_time_of_day_alarm_clock.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BCD time-of-day alarm clock testbench
// Drives set-time, add-alarm, tick and unused commands into the clock: a
// directed opening over wraps, carries, out-of-range sets, duplicate and
// unreachable alarms, then random sequences that park the time on stored
// alarms or just before carries and tick through them. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bcd_time_of_day_alarm_clock;
   import bcdclk_pkg::*;

   localparam int SLOTS        = DEFAULT_ALARM_SLOTS;
   localparam int ITEM_TARGET  = 550;
   localparam int CALM_ITEMS   = 60;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_action;
   logic [4:0] req_hours_in;
   logic [5:0] req_minutes_in;
   logic [5:0] req_seconds_in;
   logic       rsp_strobe;
   logic [1:0] rsp_hour_tens;
   logic [3:0] rsp_hour_units;
   logic [2:0] rsp_minute_tens;
   logic [3:0] rsp_minute_units;
   logic [2:0] rsp_second_tens;
   logic [3:0] rsp_second_units;
   logic       rsp_alarm_match;
   logic       rsp_alarm_dropped;

   int          failures;
   int          owed;
   int          commands_sent;
   int          alarms_added;
   bit          gaps_enabled;
   logic [10:0] ringable_alarms [$];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   bcd_time_of_day_alarm_clock #(
      .ALARM_SLOTS(SLOTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_hours_in     (req_hours_in),
      .req_minutes_in   (req_minutes_in),
      .req_seconds_in   (req_seconds_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_hour_tens    (rsp_hour_tens),
      .rsp_hour_units   (rsp_hour_units),
      .rsp_minute_tens  (rsp_minute_tens),
      .rsp_minute_units (rsp_minute_units),
      .rsp_second_tens  (rsp_second_tens),
      .rsp_second_units (rsp_second_units),
      .rsp_alarm_match  (rsp_alarm_match),
      .rsp_alarm_dropped(rsp_alarm_dropped)
   );

   bcd_time_of_day_alarm_clock_checker #(
      .ALARM_SLOTS(SLOTS)
   ) clock_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_hours_in     (req_hours_in),
      .req_minutes_in   (req_minutes_in),
      .req_seconds_in   (req_seconds_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_hour_tens    (rsp_hour_tens),
      .rsp_hour_units   (rsp_hour_units),
      .rsp_minute_tens  (rsp_minute_tens),
      .rsp_minute_units (rsp_minute_units),
      .rsp_second_tens  (rsp_second_tens),
      .rsp_second_units (rsp_second_units),
      .rsp_alarm_match  (rsp_alarm_match),
      .rsp_alarm_dropped(rsp_alarm_dropped),
      .failure_count    (failures),
      .readings_owed    (owed)
   );

   // optional idle burst, then hold the command until the clock takes it
   task automatic issue_command(input action_type act, input logic [4:0] hrs,
                                input logic [5:0] mins, input logic [5:0] secs);
      int gap;
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         start          <= 1'b0;
         req_action     <= action_type'($urandom_range(0, 3));
         req_hours_in   <= 5'($urandom_range(0, 31));
         req_minutes_in <= 6'($urandom_range(0, 63));
         req_seconds_in <= 6'($urandom_range(0, 63));
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_action     <= act;
      req_hours_in   <= hrs;
      req_minutes_in <= mins;
      req_seconds_in <= secs;
      while (busy) @(negedge clock);
      @(posedge clock);
      commands_sent++;
      if (act == ACT_ADD && alarms_added < SLOTS) begin
         alarms_added++;
         if (hrs <= HOUR_MAX && mins <= MINSEC_MAX) ringable_alarms.push_back({hrs, mins});
      end
   endtask

   task automatic run_ticks(input int count);
      repeat (count) begin
         issue_command(ACT_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      #500_000;
      $display("FAIL bcd_time_of_day_alarm_clock");
      $finish;
   end

   initial begin
      int          pick;
      int          hrs_pick;
      logic [10:0] entry;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_TICK;
      req_hours_in   = '0;
      req_minutes_in = '0;
      req_seconds_in = '0;
      commands_sent  = 0;
      alarms_added   = 0;
      gaps_enabled   = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick on an empty store, unused action, duplicate and unreachable alarms
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_NONE, 5'd31, 6'd63, 6'd63);
      issue_command(ACT_ADD, 5'd12, 6'd0, 6'd0);
      issue_command(ACT_ADD, 5'd12, 6'd0, 6'd63);
      issue_command(ACT_ADD, 5'd31, 6'd63, 6'd0);
      issue_command(ACT_TICK, 5'd31, 6'd63, 6'd63);
      // out-of-range sets hold each part
      issue_command(ACT_SET, 5'd31, 6'd63, 6'd63);
      issue_command(ACT_SET, 5'd24, 6'd60, 6'd60);
      // day wrap and hour carries
      issue_command(ACT_SET, 5'd23, 6'd59, 6'd59);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_SET, 5'd9, 6'd59, 6'd59);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_SET, 5'd19, 6'd59, 6'd59);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      // ring on the last second of the alarm minute, silent on the next
      issue_command(ACT_SET, 5'd12, 6'd0, 6'd59);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_SET, 5'd0, 6'd0, 6'd0);
      issue_command(ACT_SET, 5'd23, 6'd63, 6'd0);
      issue_command(ACT_SET, 5'd31, 6'd59, 6'd30);
      issue_command(ACT_TICK, 5'd0, 6'd0, 6'd0);

      while (commands_sent < ITEM_TARGET) begin
         gaps_enabled = (commands_sent < ITEM_TARGET - CALM_ITEMS);
         pick = $urandom_range(0, 99);
         if (pick < 40 && ringable_alarms.size() > 0) begin
            entry = ringable_alarms[$urandom_range(0, ringable_alarms.size() - 1)];
            issue_command(ACT_SET, entry[10:6], entry[5:0],
                          6'($urandom_range(0, 1) ? $urandom_range(55, 59)
                                                  : $urandom_range(0, 59)));
            run_ticks($urandom_range(1, 6));
         end else if (pick < 60) begin
            case ($urandom_range(0, 3))
               0:       hrs_pick = 9;
               1:       hrs_pick = 19;
               2:       hrs_pick = HOUR_MAX;
               default: hrs_pick = $urandom_range(0, HOUR_MAX);
            endcase
            issue_command(ACT_SET, 5'(hrs_pick),
                          6'($urandom_range(0, 1) ? MINSEC_MAX : $urandom_range(0, 59)),
                          6'($urandom_range(55, 59)));
            run_ticks($urandom_range(1, 8));
         end else if (pick < 75) begin
            run_ticks($urandom_range(1, 5));
         end else if (pick < 85) begin
            if ($urandom_range(0, 4) == 0) begin
               issue_command(ACT_ADD, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)));
            end else begin
               issue_command(ACT_ADD, 5'($urandom_range(0, HOUR_MAX)),
                             6'($urandom_range(0, MINSEC_MAX)), 6'($urandom_range(0, 63)));
            end
         end else if (pick < 95) begin
            issue_command(ACT_SET, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)));
         end else begin
            issue_command(ACT_NONE, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && owed == 0) begin
         $display("PASS bcd_time_of_day_alarm_clock");
      end else begin
         $display("FAIL bcd_time_of_day_alarm_clock");
      end
      $finish;
   end

endmodule
